[design/nfcp_pkg.sv]
// Shared types and constants for the NFC response frame parser.
// Used by every module of the block but nfcp_in_stage; depends on nothing.
package nfcp_pkg;

    localparam int unsigned SCAN_WINDOW = 16;
    localparam int unsigned READ_LENGTH = 264;
    localparam int unsigned POS_W       = $clog2(READ_LENGTH + 1);

    // Position limits of the read and of the start pattern search
    localparam logic [POS_W-1:0] POS_READ_END  = POS_W'(READ_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(READ_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_SCAN_MIN  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SCAN_END  = POS_W'(SCAN_WINDOW + 2);
    localparam logic [POS_W-1:0] POS_SCAN_LAST = POS_W'(SCAN_WINDOW + 1);

    localparam logic [7:0] FRAME_ID_IN = 8'hD5;
    localparam logic [7:0] START_CODE  = 8'hFF;
    localparam logic [7:0] MIN_LEN     = 8'd2;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAPACITY = 1'b1;

    typedef enum logic [2:0] {
        PH_SCAN = 3'd0,
        PH_LEN  = 3'd1,
        PH_LCS  = 3'd2,
        PH_TFI  = 3'd3,
        PH_CMD  = 3'd4,
        PH_BODY = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] expected_command;
        logic [7:0] payload_capacity;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_length;
        t_status    status;
        logic [7:0] payload_byte;
        logic       is_verdict;
    } t_result;

endpackage

[design/nfcp_in_stage.sv]
// Input register of the frame parser: holds one accepted byte and its start mark.
// Depends on nothing but the clock and reset.
module nfcp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_start
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       w_accept;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte  <= i_byte;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;

endmodule

[design/nfcp_cfg_regs.sv]
// Configuration registers of the frame parser: expected command and payload capacity.
// Depends on nfcp_pkg.
module nfcp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output nfcp_pkg::t_cfg                 o_cfg
);

    nfcp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_command <= 8'd0;
            r_cfg.payload_capacity <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nfcp_pkg::CFG_EXPECTED_COMMAND: r_cfg.expected_command <= i_cfg_data;
                nfcp_pkg::CFG_PAYLOAD_CAPACITY: r_cfg.payload_capacity <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/nfcp_core.sv]
// Parse state and per-byte decision logic of the frame parser.
// Depends on nfcp_pkg.
module nfcp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  nfcp_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output nfcp_pkg::t_result   o_res
);

    localparam int unsigned PW = nfcp_pkg::POS_W;

    logic [PW-1:0]    r_pos,    n_pos;
    nfcp_pkg::t_phase r_phase,  n_phase;
    logic [15:0]      r_recent, n_recent;
    logic [7:0]       r_len,    n_len;
    logic [7:0]       r_sum,    n_sum;
    logic [7:0]       r_count,  n_count;
    logic             r_done,   n_done;

    always_comb begin
        logic [PW-1:0]    c_pos;
        nfcp_pkg::t_phase c_phase;
        logic [15:0]      c_recent;
        logic [7:0]       c_len;
        logic [7:0]       c_sum;
        logic [7:0]       c_count;
        logic             c_done;
        logic             verdict;
        logic             in_body;
        nfcp_pkg::t_status st;
        logic [PW:0]      frame_end;

        // A start mark restarts parsing before this byte is looked at
        c_pos    = i_start ? '0 : r_pos;
        c_phase  = i_start ? nfcp_pkg::PH_SCAN : r_phase;
        c_recent = i_start ? 16'd0 : r_recent;
        c_len    = i_start ? 8'd0 : r_len;
        c_sum    = i_start ? 8'd0 : r_sum;
        c_count  = i_start ? 8'd0 : r_count;
        c_done   = i_start ? 1'b0 : r_done;

        n_pos    = c_pos;
        n_phase  = c_phase;
        n_recent = c_recent;
        n_len    = c_len;
        n_sum    = c_sum;
        n_count  = c_count;
        n_done   = c_done;

        verdict   = 1'b0;
        in_body   = 1'b0;
        st        = nfcp_pkg::ST_OK;
        frame_end = (PW+1)'(c_pos) + (PW+1)'(c_len) - (PW+1)'(1);

        o_res_valid = 1'b0;
        o_res       = '0;

        if (!c_done && (c_pos < nfcp_pkg::POS_READ_END)) begin
            n_pos = c_pos + PW'(1);
            unique case (c_phase)
                nfcp_pkg::PH_SCAN: begin
                    n_recent = {c_recent[7:0], i_byte};
                    if ((c_pos >= nfcp_pkg::POS_SCAN_MIN) && (c_pos < nfcp_pkg::POS_SCAN_END)
                        && (c_recent == 16'd0) && (i_byte == nfcp_pkg::START_CODE)) begin
                        n_phase = nfcp_pkg::PH_LEN;
                    end else if (c_pos >= nfcp_pkg::POS_SCAN_LAST) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_MISMATCH;
                    end
                end
                nfcp_pkg::PH_LEN: begin
                    n_len   = i_byte;
                    n_phase = nfcp_pkg::PH_LCS;
                end
                nfcp_pkg::PH_LCS: begin
                    if ((8'(c_len + i_byte) != 8'd0) || (c_len < nfcp_pkg::MIN_LEN)) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_CHECKSUM;
                    end else begin
                        n_phase = nfcp_pkg::PH_TFI;
                    end
                end
                nfcp_pkg::PH_TFI: begin
                    if (i_byte != nfcp_pkg::FRAME_ID_IN) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_MISMATCH;
                    end else begin
                        n_sum   = i_byte;
                        n_phase = nfcp_pkg::PH_CMD;
                    end
                end
                nfcp_pkg::PH_CMD: begin
                    if (i_byte != 8'(i_cfg.expected_command + 8'd1)) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_MISMATCH;
                    end else if (frame_end >= (PW+1)'(nfcp_pkg::READ_LENGTH)) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_OVERFLOW;
                    end else begin
                        n_sum   = 8'(c_sum + i_byte);
                        n_count = 8'd0;
                        n_phase = nfcp_pkg::PH_BODY;
                    end
                end
                default: begin
                    // Body: payload bytes, then DCS closes the frame
                    in_body = 1'b1;
                    n_sum   = 8'(c_sum + i_byte);
                    if (c_count < 8'(c_len - nfcp_pkg::MIN_LEN)) begin
                        n_count            = c_count + 8'd1;
                        o_res_valid        = 1'b1;
                        o_res.payload_byte = i_byte;
                    end else if (n_sum != 8'd0) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_CHECKSUM;
                    end else if (c_count > i_cfg.payload_capacity) begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_OVERFLOW;
                    end else begin
                        verdict = 1'b1;
                        st      = nfcp_pkg::ST_OK;
                    end
                end
            endcase

            // Last byte of the read with the header still open: force a verdict
            if (!verdict && !in_body && (c_pos == nfcp_pkg::POS_LAST)) begin
                verdict = 1'b1;
                if ((n_phase == nfcp_pkg::PH_LEN) || (n_phase == nfcp_pkg::PH_LCS)) begin
                    st = nfcp_pkg::ST_CHECKSUM;
                end else begin
                    st = nfcp_pkg::ST_MISMATCH;
                end
            end

            if (verdict) begin
                n_done               = 1'b1;
                o_res_valid          = 1'b1;
                o_res.is_verdict     = 1'b1;
                o_res.status         = st;
                o_res.payload_length = (st == nfcp_pkg::ST_OK) ? c_count : 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= nfcp_pkg::PH_SCAN;
            r_recent <= 16'd0;
            r_len    <= 8'd0;
            r_sum    <= 8'd0;
            r_count  <= 8'd0;
            r_done   <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_done   <= n_done;
        end
    end

endmodule

[design/nfcp_out_stage.sv]
// Result register of the frame parser: holds one result until the sink takes it.
// Depends on nfcp_pkg.
module nfcp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nfcp_pkg::t_result i_res,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output nfcp_pkg::t_result o_res
);

    logic              r_valid;
    nfcp_pkg::t_result r_res;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[design/nfc_response_frame_parser.sv]
// Each byte is held in the input register; the result it makes is loaded into the result
// register, which presents it on the master side.
// Throughput: one byte per cycle when not stalled; the parse state updates once per byte.
// The input stalls only while the result register holds a result the sink has not taken.
// Reset (i_rst_n low, synchronous): parser back to searching at position 0, both
// stages empty, expected_command 0 and payload_capacity 255.
// Depends on nfcp_pkg, nfcp_in_stage, nfcp_cfg_regs, nfcp_core, nfcp_out_stage.
module nfc_response_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Byte stream in
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tuser,  // [0] start_of_read
    // Result stream out
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] payload_byte, [9:8] status, [17:10] payload_length, [23:18] zero
    output logic [23:0]                    o_m_axis_tdata,
    output logic                           o_m_axis_tlast,  // is_verdict
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic              w_in_valid;
    logic [7:0]        w_in_byte;
    logic              w_in_start;
    logic              w_out_room;
    logic              w_fire;
    logic              w_res_valid;
    nfcp_pkg::t_result w_res;
    nfcp_pkg::t_result w_out_res;
    nfcp_pkg::t_cfg    w_cfg;

    // Advance the held byte whenever the result register can take what it makes
    assign w_fire = w_in_valid && w_out_room;

    nfcp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte),
        .o_start (w_in_start)
    );

    nfcp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Header checks, checksum and payload count for each byte
    nfcp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (w_in_byte),
        .i_start     (w_in_start),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Bytes that give no result (header, ignored tail) simply drop out here
    nfcp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .o_room  (w_out_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out_res)
    );

    assign o_m_axis_tdata = {6'd0, w_out_res.payload_length, w_out_res.status,
                             w_out_res.payload_byte};
    assign o_m_axis_tlast = w_out_res.is_verdict;

endmodule

[design/nfcp_checker.sv]
// Port-level checks for the NFC response frame parser, bound to its top level.
// Depends on nfcp_pkg and nfc_response_frame_parser.
module nfcp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Payload transfers carry no status and no length
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[17:8] == 10'd0)
        else $error("payload result carries status or length");

    // A failing verdict reports no length and no payload byte
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tdata[9:8] != 2'(nfcp_pkg::ST_OK))
            |-> (o_m_axis_tdata[17:10] == 8'd0) && (o_m_axis_tdata[7:0] == 8'd0))
        else $error("failing verdict carries length or data");

    // An ok verdict never exceeds the largest possible payload
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tdata[9:8] == 2'(nfcp_pkg::ST_OK))
            |-> (o_m_axis_tdata[17:10] <= 8'd253) && (o_m_axis_tdata[23:18] == 6'd0))
        else $error("ok verdict length out of range");

endmodule

bind nfc_response_frame_parser nfcp_checker u_nfcp_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for nfc_response_frame_parser: byte reads in, payload/verdict
// results out, checked against an in-bench frame parser. Depends on nfcp_pkg and the RTL.
module tb;
    import nfcp_pkg::*;

    localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer before giving up
    localparam int LONG_HOLD     = 400;   // receiver hold-off used to back the block up
    localparam int PHASE_ITEMS   = 350;   // bytes of random reads per register setting
    localparam int NUM_PHASES    = 5;
    localparam int SETTLE_CYCLES = 8;     // covers the result latency with margin
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       sor;
    } t_read_byte;

    // Shapes of generated reads: well-formed frames and each way a frame can break
    typedef enum int {
        FR_GOOD, FR_BAD_LCS, FR_SHORT_LEN, FR_BAD_TFI, FR_BAD_CMD,
        FR_BAD_DCS, FR_TOO_LONG, FR_NO_START, FR_CUT, FR_NOISE
    } t_frame_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    nfc_response_frame_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame parser shadow: register copies and per-read parse state
    // ------------------------------------------------------------------
    logic [7:0] cfg_cmd;
    logic [7:0] cfg_cap;
    logic [8:0] rd_pos;
    t_phase     rd_phase;
    logic [15:0] last_two;      // last two bytes seen while hunting for 00 00 FF
    logic [7:0] frm_len;
    logic [7:0] body_sum;
    logic [7:0] body_count;
    bit         verdict_out;

    t_result    pending_results[$];
    t_read_byte read_bytes_q[$];

    int error_count = 0;

    function automatic void restart_read();
        rd_pos      = '0;
        rd_phase    = PH_SCAN;
        last_two    = '0;
        frm_len     = '0;
        body_sum    = '0;
        body_count  = '0;
        verdict_out = 1'b0;
    endfunction

    function automatic void push_verdict(input t_status st, input logic [7:0] len);
        t_result r;
        verdict_out      = 1'b1;
        r.is_verdict     = 1'b1;
        r.payload_byte   = '0;
        r.status         = st;
        r.payload_length = (st == ST_OK) ? len : 8'd0;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow parser by one accepted byte and queue what it must emit
    function automatic void parse_byte(input logic [7:0] b, input logic sor);
        int unsigned p;
        logic [15:0] prev_two;
        logic [7:0]  lcs_sum;
        logic [7:0]  want_cmd;
        t_result     r;

        if (sor)
            restart_read();
        // Rest of the read after a verdict, and anything past its end, is dropped
        if (verdict_out || rd_pos >= POS_READ_END)
            return;
        p      = 32'(rd_pos);
        rd_pos = rd_pos + 9'd1;

        case (rd_phase)
            PH_SCAN: begin
                prev_two = last_two;
                last_two = {last_two[7:0], b};
                if (p >= 2 && p - 2 < SCAN_WINDOW && prev_two == 16'h0000 &&
                    b == START_CODE) begin
                    rd_phase = PH_LEN;
                end else if (p >= 2 && p - 2 >= SCAN_WINDOW - 1) begin
                    // last candidate start position has passed
                    push_verdict(ST_MISMATCH, '0);
                    return;
                end
            end
            PH_LEN: begin
                frm_len  = b;
                rd_phase = PH_LCS;
            end
            PH_LCS: begin
                lcs_sum = frm_len + b;
                if (lcs_sum != 8'd0 || frm_len < MIN_LEN) begin
                    push_verdict(ST_CHECKSUM, '0);
                    return;
                end
                rd_phase = PH_TFI;
            end
            PH_TFI: begin
                if (b != FRAME_ID_IN) begin
                    push_verdict(ST_MISMATCH, '0);
                    return;
                end
                body_sum = b;
                rd_phase = PH_CMD;
            end
            PH_CMD: begin
                want_cmd = cfg_cmd + 8'd1;   // wraps at 255
                if (b != want_cmd) begin
                    push_verdict(ST_MISMATCH, '0);
                    return;
                end
                if (p - 1 + frm_len >= READ_LENGTH) begin
                    push_verdict(ST_OVERFLOW, '0);
                    return;
                end
                body_sum   = body_sum + b;
                body_count = '0;
                rd_phase   = PH_BODY;
            end
            default: begin
                body_sum = body_sum + b;
                if (body_count < frm_len - MIN_LEN) begin
                    body_count       = body_count + 8'd1;
                    r.is_verdict     = 1'b0;
                    r.payload_byte   = b;
                    r.status         = ST_OK;
                    r.payload_length = '0;
                    pending_results.push_back(r);
                end else if (body_sum != 8'd0) begin
                    push_verdict(ST_CHECKSUM, '0);
                end else if (body_count > cfg_cap) begin
                    push_verdict(ST_OVERFLOW, '0);
                end else begin
                    push_verdict(ST_OK, body_count);
                end
                return;
            end
        endcase

        // Read ran out before the header was complete: force a verdict
        if (p == READ_LENGTH - 1) begin
            if (rd_phase == PH_LEN || rd_phase == PH_LCS)
                push_verdict(ST_CHECKSUM, '0);
            else
                push_verdict(ST_MISMATCH, '0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Read generation
    // ------------------------------------------------------------------
    bit next_sor;          // start mark for the next queued byte
    int room;              // bytes still allowed in the current read (cuts reads short)
    int planned_items = 0; // bytes that the parser actually works on
    int queued_items  = 0;
    int taken_items   = 0;

    function automatic void enqueue(input logic [7:0] b);
        t_read_byte it;
        it.data  = b;
        it.sor   = next_sor;
        next_sor = 1'b0;
        read_bytes_q.push_back(it);
        queued_items++;
    endfunction

    function automatic void put(input logic [7:0] b);
        if (room > 0) begin
            room--;
            planned_items++;
            enqueue(b);
        end
    endfunction

    function automatic void gen_read(input t_frame_kind kind);
        int          off;
        int          plen;
        int          n;
        logic [7:0]  lenb;
        logic [7:0]  sum;
        logic [7:0]  tfi;
        logic [7:0]  rsp;
        logic [7:0]  b;

        next_sor = 1'b1;
        room     = 1000;
        if (kind == FR_NOISE) begin
            // Raw garbage, with stray start marks now and then
            n = $urandom_range(1, 24);
            repeat (n) begin
                put(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 15) == 0)
                    next_sor = 1'b1;
            end
            return;
        end

        if (kind == FR_TOO_LONG)
            off = $urandom_range(4, 15);
        else
            off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        // Mostly short payloads; now and then a long one
        plen = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 253) : $urandom_range(0, 12);
        if (kind == FR_CUT)
            room = $urandom_range(1, off + plen + 7);

        repeat (off)
            put(8'($urandom_range(0, 255)));

        if (kind == FR_NO_START) begin
            // Near misses of the start pattern up to the end of the window
            repeat (18 - off) begin
                case ($urandom_range(0, 2))
                    0:       put(8'h00);
                    1:       put(8'hFF);
                    default: put(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end

        put(8'h00);
        put(8'h00);
        put(START_CODE);

        lenb = 8'(plen + 2);
        if (kind == FR_SHORT_LEN)
            lenb = 8'($urandom_range(0, 1));
        else if (kind == FR_TOO_LONG)
            lenb = 8'($urandom_range(259 - off, 255));
        put(lenb);
        put(8'(0 - lenb) + ((kind == FR_BAD_LCS) ? 8'($urandom_range(1, 255)) : 8'd0));
        if (kind == FR_BAD_LCS || kind == FR_SHORT_LEN)
            return;

        tfi = FRAME_ID_IN ^ ((kind == FR_BAD_TFI) ? 8'($urandom_range(1, 255)) : 8'd0);
        put(tfi);
        if (kind == FR_BAD_TFI)
            return;

        rsp = (cfg_cmd + 8'd1) ^ ((kind == FR_BAD_CMD) ? 8'($urandom_range(1, 255)) : 8'd0);
        put(rsp);
        if (kind == FR_BAD_CMD || kind == FR_TOO_LONG)
            return;

        sum = tfi + rsp;
        repeat (plen) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            put(b);
        end
        put(8'(0 - sum) + ((kind == FR_BAD_DCS) ? 8'($urandom_range(1, 255)) : 8'd0));

        // Trailing bytes of the read after the verdict: the block must drop them
        repeat ($urandom_range(0, 2))
            enqueue(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Byte driver: bursts of random length separated by random gaps.
    // Feed the shadow parser on every accepted transfer.
    // ------------------------------------------------------------------
    int         gap_left   = 0;
    int         burst_left = 0;
    t_read_byte drv_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, i_s_axis_tuser);
                taken_items++;
            end
            // Hold the current byte until it is taken; otherwise pick the next slot
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (read_bytes_q.size() > 0) begin
                    drv_item = read_bytes_q.pop_front();
                    i_s_axis_tdata  <= drv_item.data;
                    i_s_axis_tuser  <= drv_item.sor;
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver back-pressure.
    // Ready cycles through free-flowing, coin-flip, mostly-stalled and
    // mostly-ready stretches; a long hold-off can be requested through rx_hold_left.
    // ------------------------------------------------------------------
    int      rx_cycle     = 0;
    int      rx_hold_left = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result tdata=%h tlast=%b",
                                       o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tlast !== want.is_verdict)
                    report_error($sformatf("is_verdict got %b want %b",
                                           o_m_axis_tlast, want.is_verdict));
                if (o_m_axis_tdata[7:0] !== want.payload_byte)
                    report_error($sformatf("payload_byte got %h want %h",
                                           o_m_axis_tdata[7:0], want.payload_byte));
                if (o_m_axis_tdata[9:8] !== want.status)
                    report_error($sformatf("status got %0d want %0d",
                                           o_m_axis_tdata[9:8], want.status));
                if (o_m_axis_tdata[17:10] !== want.payload_length)
                    report_error($sformatf("payload_length got %0d want %0d",
                                           o_m_axis_tdata[17:10], want.payload_length));
                if (o_m_axis_tdata[23:18] !== 6'd0)
                    report_error($sformatf("tdata padding got %h", o_m_axis_tdata[23:18]));
            end
        end

        rx_cycle++;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= (rx_cycle % 7 != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("nfc_response_frame_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        // Transfer happened at this edge: mirror it in the shadow registers
        if (idx == CFG_EXPECTED_COMMAND)
            cfg_cmd = val;
        else
            cfg_cap = val;
        i_cfg_valid <= 1'b0;
    endtask

    // Stop feeding until every queued byte is taken and every result has come out
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (taken_items != queued_items || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    logic [7:0] cmd_set [NUM_PHASES] = '{8'h00, 8'hFF, 8'h4A, 8'h00, 8'h80};
    logic [7:0] cap_set [NUM_PHASES] = '{8'hFF, 8'hFF, 8'h00, 8'h05, 8'hFF};
    logic [7:0] boot_frame [8] = '{8'h00, 8'h00, 8'hFF, 8'h02, 8'hFE, 8'hD5, 8'h01, 8'h2A};

    initial begin
        int target;
        cfg_cmd = 8'h00;
        cfg_cap = 8'hFF;
        restart_read();
        cmd_set[3] = 8'($urandom_range(0, 255));
        cap_set[3] = 8'($urandom_range(1, 12));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed reads. First one without a start mark: the block treats it
        // as a read beginning at position 0; empty payload, reset command code.
        next_sor = 1'b0;
        room     = 1000;
        foreach (boot_frame[i])
            put(boot_frame[i]);
        enqueue(8'hFF);                     // ignored after the verdict
        // Restart the read early, right after LEN: no verdict for it
        next_sor = 1'b1;
        put(8'h00);
        put(8'h00);
        put(START_CODE);
        put(8'h05);
        // Alternating FF/00 through the whole window: no start pattern
        next_sor = 1'b1;
        for (int i = 0; i < 18; i++)
            put(i[0] ? 8'h00 : 8'hFF);
        wait_drained();

        // Random reads under several register settings; registers change only
        // while the block is drained
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_EXPECTED_COMMAND, cmd_set[ph]);
                write_reg(CFG_PAYLOAD_CAPACITY, cap_set[ph]);
            end
            if (ph == 1) begin
                // Back the block up: receiver holds off while bytes keep coming
                @(negedge i_clk);
                rx_hold_left = LONG_HOLD;
            end
            target = planned_items + PHASE_ITEMS;
            while (planned_items < target) begin
                int k;
                k = $urandom_range(0, 18);
                gen_read((k < 10) ? FR_GOOD : t_frame_kind'(k - 9));
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("nfc_response_frame_parser test passed");
        else
            $display("nfc_response_frame_parser test failed");
        $finish;
    end

endmodule
